>>> rtl/core/bcsd_pkg.sv
// ============================================================================
// bcsd_pkg
// Shared types, frame identifiers and constants of the battery CAN decoder.
// ============================================================================
`default_nettype none

package bcsd_pkg;

    localparam int CELL_COUNT_DEF = 108;
    localparam int CELL_FRAMES    = 27;
    localparam int IN_W           = 80;
    localparam int OUT_W          = 184;
    localparam int ROW_DATA_W     = 64;

    localparam logic [6:0]  CELLS_IN_USE_RST = 7'd108;
    localparam logic [15:0] DEF_CELL_MV      = 16'd3700;
    localparam logic [12:0] CUR_OFFSET       = 13'd600;
    localparam logic [8:0]  TEMP_OFFSET      = 9'd40;
    localparam logic [7:0]  CONTACTOR_MASK   = 8'h18;
    localparam logic [7:0]  DIAG_MASK        = 8'hE0;

    localparam logic [10:0] ID_STATUS  = 11'h125;
    localparam logic [10:0] ID_LIMITS  = 11'h127;
    localparam logic [10:0] ID_ILOCK   = 11'h31B;
    localparam logic [10:0] ID_TEMP    = 11'h358;
    localparam logic [10:0] ID_DIAG    = 11'h594;
    localparam logic [10:0] ID_INSUL   = 11'h6D0;
    localparam logic [10:0] ID_SNAP    = 11'h6FF;

    localparam logic [10:0] CELL_IDS [CELL_FRAMES] = '{
        11'h6D3, 11'h6D4, 11'h6E1, 11'h6E2, 11'h6E7, 11'h6E8, 11'h6E9,
        11'h6EB, 11'h6ED, 11'h6EE, 11'h6EF, 11'h6F0, 11'h6F1, 11'h6F2,
        11'h6F3, 11'h6F4, 11'h6F5, 11'h6F6, 11'h6F7, 11'h6F8, 11'h6F9,
        11'h6FA, 11'h6FB, 11'h6FC, 11'h6FD, 11'h6FE, 11'h6FF
    };

    typedef struct packed {
        logic [7:0]  byte7;
        logic [7:0]  byte6;
        logic [7:0]  byte5;
        logic [7:0]  byte4;
        logic [7:0]  byte3;
        logic [7:0]  byte2;
        logic [7:0]  byte1;
        logic [7:0]  byte0;
        logic [10:0] frame_id;
    } frame_t;

    typedef struct packed {
        logic                  status_we;
        logic [9:0]            soc;
        logic [1:0]            contactor;
        logic [8:0]            voltage;
        logic signed [12:0]    current;
        logic                  limits_we;
        logic [9:0]            charge_lim;
        logic [9:0]            discharge_lim;
        logic                  ilock_we;
        logic                  ilock;
        logic                  temp_we;
        logic signed [8:0]     temp_high;
        logic signed [8:0]     temp_low;
        logic                  diag_we;
        logic [2:0]            diag;
        logic                  insul_we;
        logic [15:0]           insul;
    } upd_t;

    typedef struct packed {
        logic       wr_en;
        logic [4:0] row;
        logic       start;
    } cell_cmd_t;

    typedef struct packed {
        logic       hit;
        logic [4:0] row;
    } slot_t;

    function automatic slot_t cell_slot(input logic [10:0] id);
        slot_t s;
        s = '0;
        for (int i = 0; i < CELL_FRAMES; i++)
        begin
            if (CELL_IDS[i] == id)
            begin
                s.hit = 1'b1;
                s.row = 5'(i);
            end
        end
        return s;
    endfunction

endpackage

`default_nettype wire

>>> rtl/core/bcsd_ram.sv
// ============================================================================
// bcsd_ram
// Generic single-write, single-read RAM with registered read data.
// ============================================================================
`default_nettype none

module bcsd_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 27,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

>>> rtl/core/bcsd_frame_decode.sv
// ============================================================================
// bcsd_frame_decode
// Decodes pack signal fields of one received frame by identifier.
// ============================================================================
`default_nettype none

module bcsd_frame_decode
    import bcsd_pkg::*;
(
    input  wire frame_t frame,
    output upd_t        upd,
    output cell_cmd_t   cmd,
    output logic [ROW_DATA_W-1:0] row_data
);

    slot_t slot;

    always_comb
    begin
        slot = cell_slot(frame.frame_id);
        upd  = '0;

        upd.soc           = {frame.byte0, frame.byte1[7:6]};
        upd.contactor     = 2'((frame.byte2 & CONTACTOR_MASK) >> 3);
        upd.voltage       = {frame.byte3, frame.byte4[7]};
        upd.current       = $signed({1'b0, frame.byte4[3:0], frame.byte5} - CUR_OFFSET);
        upd.charge_lim    = {frame.byte0, frame.byte1[7:6]};
        upd.discharge_lim = {frame.byte2[5:0], frame.byte3[7:4]};
        upd.ilock         = frame.byte1[4];
        upd.temp_high     = $signed({1'b0, frame.byte6} - TEMP_OFFSET);
        upd.temp_low      = $signed({1'b0, frame.byte7} - TEMP_OFFSET);
        upd.diag          = 3'((frame.byte6 & DIAG_MASK) >> 5);
        upd.insul         = {frame.byte2, frame.byte3};

        upd.status_we = (frame.frame_id == ID_STATUS);
        upd.limits_we = (frame.frame_id == ID_LIMITS);
        upd.ilock_we  = (frame.frame_id == ID_ILOCK);
        upd.temp_we   = (frame.frame_id == ID_TEMP);
        upd.diag_we   = (frame.frame_id == ID_DIAG);
        upd.insul_we  = (frame.frame_id == ID_INSUL);

        cmd.wr_en = slot.hit;
        cmd.row   = slot.row;
        cmd.start = (frame.frame_id == ID_SNAP);

        row_data = {frame.byte6, frame.byte7, frame.byte4, frame.byte5,
                    frame.byte2, frame.byte3, frame.byte0, frame.byte1};
    end

endmodule

`default_nettype wire

>>> rtl/core/bcsd_cell_scan.sv
// ============================================================================
// bcsd_cell_scan
// Cell voltage store (four cells per row) and min/max snapshot scanner.
// ============================================================================
`default_nettype none

module bcsd_cell_scan
    import bcsd_pkg::*;
#(
    parameter int CELL_COUNT = CELL_COUNT_DEF,
    localparam int ROWS  = (CELL_COUNT + 3) / 4,
    localparam int ROW_W = (ROWS > 1) ? $clog2(ROWS) : 1
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire cell_cmd_t             cmd,
    input  wire logic [ROW_DATA_W-1:0] row_data,
    input  wire logic [6:0]            cells_in_use,
    output logic                       done,
    output logic [15:0]                snap_min,
    output logic [15:0]                snap_max
);

    logic [ROWS-1:0]       row_vld_reg;
    logic                  busy_reg;
    logic [ROW_W-1:0]      issue_row_reg;
    logic [ROW_W-1:0]      lim_row_reg;
    logic                  pend_reg;
    logic                  pend_last_reg;
    logic                  empty_reg;
    logic                  done_reg;
    logic                  seen_reg;
    logic [15:0]           snap_min_reg;
    logic [15:0]           snap_max_reg;
    logic [ROW_W-1:0]      pend_row_reg;
    logic                  rvld_reg;
    logic [6:0]            n_reg;
    logic [15:0]           run_min_reg;
    logic [15:0]           run_max_reg;

    logic                  wr_ok;
    logic [ROW_DATA_W-1:0] rdata;
    logic [6:0]            n_eff;
    logic [7:0]            nrows;
    logic [ROW_W-1:0]      last_row;
    logic                  finalize;
    logic [15:0]           cur_min;
    logic [15:0]           cur_max;
    logic                  cur_seen;
    logic [15:0]           v;
    logic [7:0]            idx;

    assign wr_ok = cmd.wr_en && (cmd.row < 5'(ROWS));

    bcsd_ram #(
        .WIDTH (ROW_DATA_W),
        .DEPTH (ROWS)
    ) u_ram (
        .clk   (clk),
        .we    (wr_ok),
        .waddr (cmd.row[ROW_W-1:0]),
        .wdata (row_data),
        .raddr (issue_row_reg),
        .rdata (rdata)
    );

    always_comb
    begin
        n_eff    = (cells_in_use > 7'(CELL_COUNT)) ? 7'(CELL_COUNT) : cells_in_use;
        nrows    = ({1'b0, n_eff} + 8'd3) >> 2;
        last_row = ROW_W'(nrows - 8'd1);
        finalize = (pend_reg && pend_last_reg) || empty_reg;

        cur_min  = run_min_reg;
        cur_max  = run_max_reg;
        cur_seen = seen_reg;
        for (int k = 0; k < 4; k++)
        begin
            v   = rdata[16*k +: 16];
            idx = {6'(pend_row_reg), 2'(k)};
            if (pend_reg && rvld_reg && (v != 16'd0) && (idx < {1'b0, n_reg}))
            begin
                cur_seen = 1'b1;
                if (v < cur_min)
                begin
                    cur_min = v;
                end
                if (v > cur_max)
                begin
                    cur_max = v;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_vld_reg   <= '0;
            busy_reg      <= 1'b0;
            issue_row_reg <= '0;
            lim_row_reg   <= '0;
            pend_reg      <= 1'b0;
            pend_last_reg <= 1'b0;
            empty_reg     <= 1'b0;
            done_reg      <= 1'b0;
            seen_reg      <= 1'b0;
            snap_min_reg  <= DEF_CELL_MV;
            snap_max_reg  <= DEF_CELL_MV;
        end
        else
        begin
            if (wr_ok)
            begin
                row_vld_reg[cmd.row[ROW_W-1:0]] <= 1'b1;
            end
            pend_reg      <= busy_reg;
            pend_last_reg <= busy_reg && (issue_row_reg == lim_row_reg);
            done_reg      <= finalize;
            empty_reg     <= 1'b0;
            if (cmd.start)
            begin
                busy_reg      <= (nrows != 8'd0);
                empty_reg     <= (nrows == 8'd0);
                issue_row_reg <= '0;
                lim_row_reg   <= last_row;
                seen_reg      <= 1'b0;
            end
            else
            begin
                if (busy_reg)
                begin
                    issue_row_reg <= ROW_W'(issue_row_reg + 1'b1);
                    if (issue_row_reg == lim_row_reg)
                    begin
                        busy_reg <= 1'b0;
                    end
                end
                seen_reg <= cur_seen;
            end
            if (finalize)
            begin
                snap_min_reg <= cur_seen ? cur_min : DEF_CELL_MV;
                snap_max_reg <= cur_seen ? cur_max : DEF_CELL_MV;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        pend_row_reg <= issue_row_reg;
        rvld_reg     <= row_vld_reg[issue_row_reg];
        if (cmd.start)
        begin
            n_reg       <= n_eff;
            run_min_reg <= 16'hFFFF;
            run_max_reg <= 16'h0000;
        end
        else
        begin
            run_min_reg <= cur_min;
            run_max_reg <= cur_max;
        end
    end

    assign done     = done_reg;
    assign snap_min = snap_min_reg;
    assign snap_max = snap_max_reg;

endmodule

`default_nettype wire

>>> rtl/core/battery_can_signal_decoder_unit.sv
// Any frame but 0x6FF: signals are registered on input transfer, then the result is
//   registered in state OUT. Frame 0x6FF: state SCAN first scans the cells in use;
//   the cell RAM is read one row of four cells per cycle.
// One frame in flight: a new frame is taken only in state IDLE; a finished result waits
//   in the output register and holds back the next one.
// Reset (async, active low) clears all signals, row valid flags and snapshot to 3700.
// ============================================================================
// battery_can_signal_decoder_unit
// Decodes battery pack CAN frames into a scaled signal snapshot per frame.
// ============================================================================
`default_nettype none

module battery_can_signal_decoder_unit
    import bcsd_pkg::*;
#(
    parameter int CELL_COUNT = CELL_COUNT_DEF
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             s_tvalid,
    output logic                  s_tready,
    // frame_id, byte0 .. byte7, zero pad
    input  wire logic [IN_W-1:0]  s_tdata,
    output logic                  m_tvalid,
    input  wire logic             m_tready,
    // soc_pptt, pack_voltage_dv, pack_current_da, power_w, charge_power_w,
    // discharge_power_w, temp_min_dc, temp_max_dc, cell_min_mv, cell_max_mv,
    // insulation_kohm, status_bits
    output logic [OUT_W-1:0]      m_tdata,
    input  wire logic             cfg_we,
    input  wire logic [6:0]       cfg_wdata
);

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_SCAN = 3'b010,
        ST_OUT  = 3'b100
    } state_t;

    state_t                state_reg, state_next;
    logic [6:0]            cells_in_use_reg;
    logic [9:0]            soc_reg;
    logic [1:0]            contactor_reg;
    logic [8:0]            voltage_reg;
    logic signed [12:0]    current_reg;
    logic [9:0]            charge_lim_reg;
    logic [9:0]            discharge_lim_reg;
    logic                  ilock_reg;
    logic signed [8:0]     temp_high_reg;
    logic signed [8:0]     temp_low_reg;
    logic [2:0]            diag_reg;
    logic [15:0]           insul_reg;
    logic                  m_tvalid_reg;
    logic [OUT_W-1:0]      out_reg, out_next;

    frame_t                frame;
    upd_t                  upd;
    cell_cmd_t             dec_cmd;
    cell_cmd_t             cmd;
    logic [ROW_DATA_W-1:0] row_data;
    logic                  accept;
    logic                  scan_done;
    logic [15:0]           snap_min;
    logic [15:0]           snap_max;
    logic                  out_free;

    logic [13:0]           soc_pptt;
    logic [12:0]           volt_dv;
    logic [16:0]           cur_ext;
    logic [16:0]           cur_da;
    logic signed [22:0]    power;
    logic [18:0]           chg_p;
    logic [18:0]           dis_p;
    logic [12:0]           tlo_ext;
    logic [12:0]           thi_ext;
    logic [12:0]           tlo_dc;
    logic [12:0]           thi_dc;
    logic [5:0]            status;

    assign frame = frame_t'(s_tdata[74:0]);

    bcsd_frame_decode u_dec (
        .frame    (frame),
        .upd      (upd),
        .cmd      (dec_cmd),
        .row_data (row_data)
    );

    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign out_free = !m_tvalid_reg || m_tready;

    always_comb
    begin
        cmd       = dec_cmd;
        cmd.wr_en = accept && dec_cmd.wr_en;
        cmd.start = accept && dec_cmd.start;
    end

    bcsd_cell_scan #(
        .CELL_COUNT (CELL_COUNT)
    ) u_scan (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .row_data     (row_data),
        .cells_in_use (cells_in_use_reg),
        .done         (scan_done),
        .snap_min     (snap_min),
        .snap_max     (snap_max)
    );

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = dec_cmd.start ? ST_SCAN : ST_OUT;
                end
            end
            ST_SCAN:
            begin
                if (scan_done)
                begin
                    state_next = ST_OUT;
                end
            end
            ST_OUT:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        soc_pptt = 14'({soc_reg, 3'b000}) + 14'({soc_reg, 1'b0});
        volt_dv  = 13'({voltage_reg, 3'b000}) + 13'({voltage_reg, 1'b0});
        cur_ext  = {{4{current_reg[12]}}, current_reg};
        cur_da   = (cur_ext << 3) + (cur_ext << 1);
        power    = $signed({1'b0, voltage_reg}) * current_reg;
        chg_p    = 19'(charge_lim_reg) * 19'(voltage_reg);
        dis_p    = 19'(discharge_lim_reg) * 19'(voltage_reg);
        tlo_ext  = {{4{temp_low_reg[8]}}, temp_low_reg};
        thi_ext  = {{4{temp_high_reg[8]}}, temp_high_reg};
        tlo_dc   = (tlo_ext << 3) + (tlo_ext << 1);
        thi_dc   = (thi_ext << 3) + (thi_ext << 1);
        status   = {diag_reg, contactor_reg, ilock_reg};
        out_next = {status, insul_reg, snap_max, snap_min, thi_dc, tlo_dc,
                    dis_p, chg_p, power[21:0], cur_da, volt_dv, soc_pptt};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= ST_IDLE;
            cells_in_use_reg  <= CELLS_IN_USE_RST;
            soc_reg           <= '0;
            contactor_reg     <= '0;
            voltage_reg       <= '0;
            current_reg       <= '0;
            charge_lim_reg    <= '0;
            discharge_lim_reg <= '0;
            ilock_reg         <= 1'b0;
            temp_high_reg     <= '0;
            temp_low_reg      <= '0;
            diag_reg          <= '0;
            insul_reg         <= '0;
            m_tvalid_reg      <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_we)
            begin
                cells_in_use_reg <= cfg_wdata;
            end
            if (accept && upd.status_we)
            begin
                soc_reg       <= upd.soc;
                contactor_reg <= upd.contactor;
                voltage_reg   <= upd.voltage;
                current_reg   <= upd.current;
            end
            if (accept && upd.limits_we)
            begin
                charge_lim_reg    <= upd.charge_lim;
                discharge_lim_reg <= upd.discharge_lim;
            end
            if (accept && upd.ilock_we)
            begin
                ilock_reg <= upd.ilock;
            end
            if (accept && upd.temp_we)
            begin
                temp_high_reg <= upd.temp_high;
                temp_low_reg  <= upd.temp_low;
            end
            if (accept && upd.diag_we)
            begin
                diag_reg <= upd.diag;
            end
            if (accept && upd.insul_we)
            begin
                insul_reg <= upd.insul;
            end
            if ((state_reg == ST_OUT) && out_free)
            begin
                m_tvalid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if ((state_reg == ST_OUT) && out_free)
        begin
            out_reg <= out_next;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = out_reg;

endmodule

`default_nettype wire

>>> rtl/core/bcsd_checker.sv
// ============================================================================
// bcsd_checker
// Port-level checks of the battery CAN decoder, bound to the top level.
// ============================================================================
`default_nettype none

module bcsd_checker
    import bcsd_pkg::*;
(
    input wire logic             clk,
    input wire logic             rst_n,
    input wire logic             s_tvalid,
    input wire logic             s_tready,
    input wire logic             m_tvalid,
    input wire logic             m_tready,
    input wire logic [OUT_W-1:0] m_tdata
);

    // one frame at a time: no back-to-back input transfer
    a_one_frame: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input taken while a frame is in process");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result changed");

    a_cell_order: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[145:130] <= m_tdata[161:146]))
        else $error("cell minimum above cell maximum");

    a_soc_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[13:0] <= 14'd10230))
        else $error("state of charge out of range");

endmodule

bind battery_can_signal_decoder_unit bcsd_checker u_bcsd_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

`default_nettype wire

>>> sim/tb_battery_can_signal_decoder_unit.sv
`timescale 1ns / 1ps
// ============================================================================
// tb_battery_can_signal_decoder_unit
// Self-checking bench for the battery CAN decoder: drives CAN frames over the
// input stream, mirrors the decoded pack signals and the cell min/max snapshot,
// and checks every result field under random idling, stalls and register
// settings.
// ============================================================================

module tb_battery_can_signal_decoder_unit;

    import bcsd_pkg::*;

    localparam int CYCLE_LIMIT = 400000;
    localparam int PHASES      = 8;
    localparam int PHASE_ITEMS = 135;
    localparam int LONG_HOLD   = 400;

    // fields from the highest bit down; soc_pptt sits at bit 0
    typedef struct packed {
        logic [5:0]         status_bits;
        logic [15:0]        insulation_kohm;
        logic [15:0]        cell_max_mv;
        logic [15:0]        cell_min_mv;
        logic signed [12:0] temp_max_dc;
        logic signed [12:0] temp_min_dc;
        logic [18:0]        discharge_power_w;
        logic [18:0]        charge_power_w;
        logic signed [21:0] power_w;
        logic signed [16:0] pack_current_da;
        logic [12:0]        pack_voltage_dv;
        logic [13:0]        soc_pptt;
    } pack_snapshot_t;

    logic             clk = 1'b0;
    logic             rst_n = 1'b0;
    logic             s_tvalid = 1'b0;
    logic             s_tready;
    logic [IN_W-1:0]  s_tdata = '0;
    logic             m_tvalid;
    logic             m_tready = 1'b0;
    logic [OUT_W-1:0] m_tdata;
    logic             cfg_we = 1'b0;
    logic [6:0]       cfg_wdata = '0;

    // mirrored block state
    logic [15:0]        cell_mv [CELL_COUNT_DEF];
    logic [6:0]         cells_cfg;
    logic [9:0]         soc_raw;
    logic [1:0]         contactor;
    logic [8:0]         volt_raw;
    int                 current_a;
    logic [9:0]         chg_limit_a;
    logic [9:0]         dis_limit_a;
    logic               interlock;
    int                 temp_hi_c;
    int                 temp_lo_c;
    logic [2:0]         insul_diag;
    logic [15:0]        insul_kohm;
    logic [15:0]        snap_min_mv;
    logic [15:0]        snap_max_mv;

    frame_t         frame_queue [$];
    pack_snapshot_t expected_snapshots [$];

    int   cycle_count = 0;
    int   mismatches = 0;
    logic in_xfer = 1'b0;
    logic idle_on = 1'b1;
    int   tx_gap = 0;
    int   rx_stall = 0;
    int   hold_requests = 0;
    int   hold_served = 0;

    battery_can_signal_decoder_unit u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    always #10 clk = ~clk;

    // updates the mirrored signals from one frame and returns the scaled snapshot
    function automatic pack_snapshot_t decode_frame(input frame_t f);
        pack_snapshot_t r;
        logic [7:0] b [8];
        int   n;
        int   lo;
        int   hi;
        int   vdv;
        int   cda;
        logic seen;
        b[0] = f.byte0; b[1] = f.byte1; b[2] = f.byte2; b[3] = f.byte3;
        b[4] = f.byte4; b[5] = f.byte5; b[6] = f.byte6; b[7] = f.byte7;
        case (f.frame_id)
            ID_STATUS:
            begin
                soc_raw   = {b[0], b[1][7:6]};
                contactor = 2'((b[2] & CONTACTOR_MASK) >> 3);
                volt_raw  = {b[3], b[4][7]};
                current_a = int'({b[4][3:0], b[5]}) - 600;
            end
            ID_LIMITS:
            begin
                chg_limit_a = {b[0], b[1][7:6]};
                dis_limit_a = {b[2][5:0], b[3][7:4]};
            end
            ID_ILOCK:  interlock = b[1][4];
            ID_TEMP:
            begin
                temp_hi_c = int'(b[6]) - 40;
                temp_lo_c = int'(b[7]) - 40;
            end
            ID_DIAG:   insul_diag = 3'((b[6] & DIAG_MASK) >> 5);
            ID_INSUL:  insul_kohm = {b[2], b[3]};
            default:
            begin
                for (int i = 0; i < CELL_FRAMES; i++)
                begin
                    if (CELL_IDS[i] == f.frame_id)
                    begin
                        for (int k = 0; k < 4; k++)
                        begin
                            if (i * 4 + k < CELL_COUNT_DEF)
                                cell_mv[i * 4 + k] = {b[2 * k], b[2 * k + 1]};
                        end
                    end
                end
                if (f.frame_id == ID_SNAP)
                begin
                    n = (cells_cfg > CELL_COUNT_DEF) ? CELL_COUNT_DEF : int'(cells_cfg);
                    lo = 32'hFFFF;
                    hi = 0;
                    seen = 1'b0;
                    for (int i = 0; i < n; i++)
                    begin
                        if (cell_mv[i] != 16'd0)
                        begin
                            seen = 1'b1;
                            if (cell_mv[i] < lo) lo = cell_mv[i];
                            if (cell_mv[i] > hi) hi = cell_mv[i];
                        end
                    end
                    snap_min_mv = seen ? 16'(lo) : DEF_CELL_MV;
                    snap_max_mv = seen ? 16'(hi) : DEF_CELL_MV;
                end
            end
        endcase
        vdv = int'(volt_raw) * 10;
        cda = current_a * 10;
        r.soc_pptt          = 14'(int'(soc_raw) * 10);
        r.pack_voltage_dv   = 13'(vdv);
        r.pack_current_da   = 17'(cda);
        r.power_w           = 22'((vdv * cda) / 100);
        r.charge_power_w    = 19'(int'(chg_limit_a) * int'(volt_raw));
        r.discharge_power_w = 19'(int'(dis_limit_a) * int'(volt_raw));
        r.temp_min_dc       = 13'(temp_lo_c * 10);
        r.temp_max_dc       = 13'(temp_hi_c * 10);
        r.cell_min_mv       = snap_min_mv;
        r.cell_max_mv       = snap_max_mv;
        r.insulation_kohm   = insul_kohm;
        r.status_bits       = {insul_diag, contactor, interlock};
        return r;
    endfunction

    task automatic check_field(input string name, input longint want, input longint got);
        if (want != got)
        begin
            mismatches++;
            $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, want, got);
        end
    endtask

    task automatic push_frame(input logic [10:0] id, input logic [63:0] payload);
        frame_t f;
        f.frame_id = id;
        f.byte0 = payload[63:56]; f.byte1 = payload[55:48];
        f.byte2 = payload[47:40]; f.byte3 = payload[39:32];
        f.byte4 = payload[31:24]; f.byte5 = payload[23:16];
        f.byte6 = payload[15:8];  f.byte7 = payload[7:0];
        frame_queue.push_back(f);
    endtask

    task automatic push_random_frames(input int count);
        logic [10:0] id;
        logic [63:0] payload;
        logic [15:0] cell_word;
        int          sel;
        for (int n = 0; n < count; n++)
        begin
            sel = $urandom_range(0, 99);
            if (sel < 35)
                id = CELL_IDS[$urandom_range(0, CELL_FRAMES - 2)];
            else if (sel < 45)
                id = ID_SNAP;
            else if (sel < 75)
            begin
                case ($urandom_range(0, 5))
                    0: id = ID_STATUS;
                    1: id = ID_LIMITS;
                    2: id = ID_ILOCK;
                    3: id = ID_TEMP;
                    4: id = ID_DIAG;
                    default: id = ID_INSUL;
                endcase
            end
            else
                id = 11'($urandom_range(0, 2047));
            if (sel < 45)
            begin
                for (int k = 0; k < 4; k++)
                begin
                    case ($urandom_range(0, 9))
                        0, 1: cell_word = 16'h0000;
                        2: cell_word = 16'hFFFF;
                        3: cell_word = 16'($urandom_range(1, 16));
                        4: cell_word = 16'($urandom);
                        default: cell_word = 16'($urandom_range(2800, 4300));
                    endcase
                    payload[63 - 16 * k -: 16] = cell_word;
                end
            end
            else
                payload = {$urandom, $urandom};
            push_frame(id, payload);
        end
    endtask

    task automatic wait_drained;
        while (frame_queue.size() != 0 || s_tvalid || expected_snapshots.size() != 0)
            @(posedge clk);
    endtask

    // stimulus driver
    always @(negedge clk)
    begin
        if (rst_n && !(s_tvalid && !in_xfer))
        begin
            if (tx_gap > 0)
            begin
                tx_gap--;
                s_tvalid <= 1'b0;
            end
            else if (idle_on && $urandom_range(0, 9) == 0)
            begin
                tx_gap = $urandom_range(1, 19) - 1;
                s_tvalid <= 1'b0;
            end
            else if (frame_queue.size() != 0)
            begin
                s_tdata  <= IN_W'(frame_queue.pop_front());
                s_tvalid <= 1'b1;
            end
            else
                s_tvalid <= 1'b0;
        end
    end

    // result receiver backpressure
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (hold_served < hold_requests)
            begin
                hold_served++;
                rx_stall = LONG_HOLD;
                m_tready <= 1'b0;
            end
            else if (rx_stall > 0)
            begin
                rx_stall--;
                m_tready <= 1'b0;
            end
            else if (idle_on && $urandom_range(0, 9) == 0)
            begin
                rx_stall = $urandom_range(1, 19) - 1;
                m_tready <= 1'b0;
            end
            else
                m_tready <= 1'b1;
        end
    end

    // monitor and predictor
    always @(posedge clk)
    begin
        pack_snapshot_t want;
        pack_snapshot_t got;
        cycle_count++;
        in_xfer <= rst_n && s_tvalid && s_tready;
        if (rst_n)
        begin
            if (cfg_we)
                cells_cfg = cfg_wdata;
            if (m_tvalid && m_tready)
            begin
                got = m_tdata;
                if (expected_snapshots.size() == 0)
                begin
                    mismatches++;
                    $display("%0t: unexpected result transfer: expected none, actual %h",
                             $time, m_tdata);
                end
                else
                begin
                    want = expected_snapshots.pop_front();
                    check_field("soc_pptt", want.soc_pptt, got.soc_pptt);
                    check_field("pack_voltage_dv", want.pack_voltage_dv, got.pack_voltage_dv);
                    check_field("pack_current_da", want.pack_current_da, got.pack_current_da);
                    check_field("power_w", want.power_w, got.power_w);
                    check_field("charge_power_w", want.charge_power_w, got.charge_power_w);
                    check_field("discharge_power_w", want.discharge_power_w,
                                got.discharge_power_w);
                    check_field("temp_min_dc", want.temp_min_dc, got.temp_min_dc);
                    check_field("temp_max_dc", want.temp_max_dc, got.temp_max_dc);
                    check_field("cell_min_mv", want.cell_min_mv, got.cell_min_mv);
                    check_field("cell_max_mv", want.cell_max_mv, got.cell_max_mv);
                    check_field("insulation_kohm", want.insulation_kohm, got.insulation_kohm);
                    check_field("status_bits", want.status_bits, got.status_bits);
                end
            end
            if (s_tvalid && s_tready)
                expected_snapshots.push_back(decode_frame(frame_t'(s_tdata[$bits(frame_t)-1:0])));
        end
    end

    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
            @(posedge clk);
        $display("battery_can_signal_decoder_unit regression: fail");
        $finish;
    end

    initial
    begin
        int cfg_plan [PHASES];
        for (int i = 0; i < CELL_COUNT_DEF; i++)
            cell_mv[i] = 16'd0;
        cells_cfg   = CELLS_IN_USE_RST;
        soc_raw     = '0;
        contactor   = '0;
        volt_raw    = '0;
        current_a   = 0;
        chg_limit_a = '0;
        dis_limit_a = '0;
        interlock   = 1'b0;
        temp_hi_c   = 0;
        temp_lo_c   = 0;
        insul_diag  = '0;
        insul_kohm  = '0;
        snap_min_mv = DEF_CELL_MV;
        snap_max_mv = DEF_CELL_MV;
        cfg_plan = '{0, 127, 1, 4, 109, 57, 108, 0};
        cfg_plan[PHASES - 1] = $urandom_range(0, 127);

        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // empty store gives the default snapshot
        push_frame(ID_SNAP, 64'h0);
        push_frame(11'h000, 64'h0);
        push_frame(11'h7FF, 64'hFFFF_FFFF_FFFF_FFFF);
        push_frame(ID_STATUS, 64'hFFFF_FFFF_FFFF_FFFF);
        push_frame(ID_LIMITS, 64'hFFFF_FFFF_FFFF_FFFF);
        push_frame(ID_TEMP, 64'hFFFF_FFFF_FFFF_FFFF);
        push_frame(ID_ILOCK, 64'hFFFF_FFFF_FFFF_FFFF);
        push_frame(ID_DIAG, 64'hFFFF_FFFF_FFFF_FFFF);
        push_frame(ID_INSUL, 64'hFFFF_FFFF_FFFF_FFFF);
        // full voltage with most negative current
        push_frame(ID_STATUS, 64'h0000_00FF_8000_0000);
        push_frame(ID_TEMP, 64'h0);
        push_frame(ID_ILOCK, 64'h0010_0000_0000_0000);
        push_frame(CELL_IDS[0], 64'h0001_FFFF_0000_1234);
        push_frame(CELL_IDS[1], 64'h8000_0E10_0000_0001);
        push_frame(ID_SNAP, 64'h0E10_0000_0FA0_0C00);
        push_frame(ID_STATUS, 64'h0);
        push_frame(ID_DIAG, 64'h0);
        push_frame(ID_INSUL, 64'h0);
        push_frame(ID_LIMITS, 64'h0);
        push_frame(CELL_IDS[CELL_FRAMES - 2], 64'h0);
        push_frame(ID_SNAP, 64'h0);
        wait_drained();

        for (int p = 0; p < PHASES; p++)
        begin
            @(negedge clk);
            cfg_we    <= 1'b1;
            cfg_wdata <= 7'(cfg_plan[p]);
            @(negedge clk);
            cfg_we    <= 1'b0;
            if (p == PHASES - 1)
                idle_on = 1'b0;
            push_random_frames(PHASE_ITEMS);
            if (p == 2)
                hold_requests++;
            wait_drained();
        end

        repeat (40) @(posedge clk);
        if (mismatches == 0 && expected_snapshots.size() == 0)
            $display("battery_can_signal_decoder_unit regression: pass");
        else
            $display("battery_can_signal_decoder_unit regression: fail");
        $finish;
    end

endmodule

>>> filelist.f
rtl/core/bcsd_pkg.sv
rtl/core/bcsd_ram.sv
rtl/core/bcsd_frame_decode.sv
rtl/core/bcsd_cell_scan.sv
rtl/core/battery_can_signal_decoder_unit.sv
rtl/core/bcsd_checker.sv
sim/tb_battery_can_signal_decoder_unit.sv
